// ===== design/bounded_list_with_even_sum_core_assert.svh =====
// Assertion macros for the bounded list core.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef BOUNDED_LIST_WITH_EVEN_SUM_CORE_ASSERT_SVH
`define BOUNDED_LIST_WITH_EVEN_SUM_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define BLWES_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("blwes: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define BLWES_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("blwes: next-cycle check failed");

`endif

// ===== design/blwes_pkg.sv =====
// Shared constants and types for the bounded list core.
// Used by blwes_cell and bounded_list_with_even_sum_core; no dependencies.
`timescale 1ns / 1ps

package blwes_pkg;

   localparam int DEPTH  = 16;
   localparam int DATA_W = 32;
   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);

   // request opcodes
   localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
   localparam logic [1:0] OP_PUSH_BACK  = 2'd1;
   localparam logic [1:0] OP_DELETE     = 2'd2;

   // response status codes
   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_FULL      = 2'd1;
   localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
   localparam logic [1:0] STAT_EMPTY     = 2'd3;

   // cell commands
   localparam logic [2:0] CELL_HOLD   = 3'd0;  // keep value
   localparam logic [2:0] CELL_PUSH   = 3'd1;  // take left neighbor, cell 0 takes data
   localparam logic [2:0] CELL_LOAD   = 3'd2;  // only the addressed cell takes data
   localparam logic [2:0] CELL_ROTATE = 3'd3;  // take right neighbor, addressed cell takes data
   localparam logic [2:0] CELL_SHIFT  = 3'd4;  // take right neighbor

   typedef struct packed {
      logic [2:0]        mode;
      logic [IDX_W-1:0]  pos;
      logic [DATA_W-1:0] data;
   } cell_cmd_type;

endpackage

// ===== design/blwes_cell.sv =====
// One storage cell of the list chain: holds one entry, trades with neighbors.
// Depends on blwes_pkg.
`timescale 1ns / 1ps

module blwes_cell
   import blwes_pkg::*;
(
   input  logic              clock,
   input  cell_cmd_type      cmd,
   input  logic [IDX_W-1:0]  cell_index,
   input  logic [DATA_W-1:0] left_data,
   input  logic [DATA_W-1:0] right_data,
   output logic [DATA_W-1:0] data
);

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;
   logic              addressed;

   assign addressed = (cmd.pos == cell_index);

   // next value select
   always_comb begin
      data_in = data_ff;
      unique case (cmd.mode)
         CELL_HOLD:   data_in = data_ff;
         CELL_PUSH:   data_in = left_data;
         CELL_LOAD:   data_in = addressed ? cmd.data : data_ff;
         CELL_ROTATE: data_in = addressed ? cmd.data : right_data;
         CELL_SHIFT:  data_in = right_data;
         default:     data_in = data_ff;
      endcase
   end

   // payload only, no reset
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// ===== design/bounded_list_with_even_sum_core.sv =====
// Bounded list core: push front and back, an unused op and a delete on an empty list answer in the cycle after accept.
// Delete runs the list once around the cell chain, one cell step per cycle:
// busy while the scan runs, with the result strobe registered from its last step.
// Receiver cannot stall; one result strobe per accepted transaction.
// Synchronous reset clears count, sum and control; cell contents are not reset.
`timescale 1ns / 1ps

module bounded_list_with_even_sum_core
   import blwes_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [1:0]               req_op,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   output logic [1:0]               rsp_status,
   output logic [CNT_W-1:0]         rsp_entry_count,
   output logic signed [DATA_W-1:0] rsp_even_sum
);

`include "bounded_list_with_even_sum_core_assert.svh"

   localparam logic S_IDLE = 1'b0;
   localparam logic S_SCAN = 1'b1;

   logic              state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [DATA_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0]  steps_ff, steps_in;
   logic [CNT_W-1:0]  live_ff, live_in;
   logic              found_ff, found_in;
   logic [DATA_W-1:0] key_ff, key_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;

   cell_cmd_type      cmd;
   logic [DATA_W-1:0] cell_data [DEPTH];
   logic [DATA_W-1:0] head;
   logic              accept;
   logic              full;
   logic              match;

   assign accept = start && (state_ff == S_IDLE);
   assign full   = (count_ff == CNT_W'(DEPTH));
   assign head   = cell_data[0];
   assign match  = (head == key_ff) && !found_ff;

   // cell chain
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_W-1:0] left_w, right_w;
      if (i == 0) begin : g_first
         assign left_w = cmd.data;
      end else begin : g_mid_l
         assign left_w = cell_data[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_w = cmd.data;
      end else begin : g_mid_r
         assign right_w = cell_data[i+1];
      end
      blwes_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .cell_index (IDX_W'(i)),
         .left_data  (left_w),
         .right_data (right_w),
         .data       (cell_data[i])
      );
   end

   // control: request decode and delete scan
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      sum_in        = sum_ff;
      steps_in      = steps_ff;
      live_in       = live_ff;
      found_in      = found_ff;
      key_in        = key_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      cmd.mode      = CELL_HOLD;
      cmd.pos       = '0;
      cmd.data      = req_value;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_OK;
               case (req_op)
                  OP_PUSH_FRONT, OP_PUSH_BACK: begin
                     if (full) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        cmd.mode = (req_op == OP_PUSH_FRONT) ? CELL_PUSH : CELL_LOAD;
                        cmd.pos  = count_ff[IDX_W-1:0];
                        count_in = count_ff + 1'b1;
                        if (!req_value[0]) begin
                           sum_in = sum_ff + req_value;
                        end
                     end
                  end
                  OP_DELETE: begin
                     if (count_ff == '0) begin
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        rsp_valid_in = 1'b0;
                        state_in     = S_SCAN;
                        key_in       = req_value;
                        steps_in     = count_ff;
                        live_in      = count_ff;
                        found_in     = 1'b0;
                     end
                  end
                  default: begin
                     rsp_status_in = STAT_OK;
                  end
               endcase
            end
         end
         S_SCAN: begin
            // head leaves cell 0; it is re-appended at the tail unless it is the match
            cmd.data = head;
            if (match) begin
               cmd.mode = CELL_SHIFT;
               live_in  = live_ff - 1'b1;
               found_in = 1'b1;
            end else begin
               cmd.mode = CELL_ROTATE;
               cmd.pos  = IDX_W'(live_ff - 1'b1);
            end
            steps_in = steps_ff - 1'b1;
            if (steps_ff == CNT_W'(1)) begin
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = found_in ? STAT_OK : STAT_NOT_FOUND;
               count_in      = live_in;
               if (found_in && !key_ff[0]) begin
                  sum_in = sum_ff - key_ff;
               end
               if (live_in == '0) begin
                  sum_in = '0;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         sum_ff       <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // scan bookkeeping and response payload
   always_ff @(posedge clock) begin
      steps_ff      <= steps_in;
      live_ff       <= live_in;
      key_ff        <= key_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy            = (state_ff == S_SCAN);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = count_ff;
   assign rsp_even_sum    = sum_ff;

   // checks
   `BLWES_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH))
   `BLWES_ASSERT_NEXT(a_quick_rsp, clock, reset, accept && req_op != OP_DELETE, rsp_valid_ff)
   `BLWES_ASSERT_NOW(a_scan_live, clock, reset, state_ff == S_SCAN, live_ff <= count_ff && steps_ff != '0)
   `BLWES_ASSERT_NOW(a_miss_keeps, clock, reset, rsp_valid_ff && rsp_status_ff == STAT_NOT_FOUND, count_ff == $past(count_ff))

endmodule

// ===== tb/bounded_list_with_even_sum_core_tb.sv =====
// Self-checking bench for bounded_list_with_even_sum_core: directed and random insert/delete
// transactions, each predicted by an in-bench list model and checked against the rsp_ strobe.
// Depends on blwes_pkg and the core RTL only.
`timescale 1ns / 1ps

module bounded_list_with_even_sum_core_tb;
   import blwes_pkg::*;

   // op code three is unused by the block: it answers with the current state
   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam int         N_RANDOM    = 1100;
   localparam int         POOL_N      = 12;
   localparam int         STALL_LIMIT = 2000;

   typedef struct {
      logic [1:0]        op;
      logic [DATA_W-1:0] value;
      bit                drain;   // hold off until all results are back
   } list_req_type;

   typedef struct {
      logic [1:0]        status;
      logic [CNT_W-1:0]  count;
      logic [DATA_W-1:0] sum;
   } list_rsp_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [1:0]               req_op = OP_PUSH_FRONT;
   logic signed [DATA_W-1:0] req_value = '0;
   logic                     rsp_valid;
   logic [1:0]               rsp_status;
   logic [CNT_W-1:0]         rsp_entry_count;
   logic signed [DATA_W-1:0] rsp_even_sum;

   list_req_type      pending[$];
   list_rsp_type      expected_rsp[$];
   logic [DATA_W-1:0] list_model[$];
   logic [DATA_W-1:0] even_total = '0;
   logic [DATA_W-1:0] value_pool[POOL_N];
   list_req_type      head_item;
   int                n_items = 0;
   int                n_accepted = 0;
   int                n_checked = 0;
   int                n_errors = 0;
   int                gap_left = 0;
   int                nogap_left = 0;
   int                stall_cycles = 0;

   bounded_list_with_even_sum_core u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_op          (req_op),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count),
      .rsp_even_sum    (rsp_even_sum)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      $display("mismatch: %s", what);
      n_errors++;
   endtask

   function automatic void queue_item(input logic [1:0] op, input logic [DATA_W-1:0] value,
                                      input bit drain);
      list_req_type item;
      item.op    = op;
      item.value = value;
      item.drain = drain;
      pending.push_back(item);
      n_items++;
   endfunction

   // Apply one transaction to the list model and store the response it must give
   function automatic void predict_list_op(input logic [1:0] op,
                                           input logic [DATA_W-1:0] value);
      list_rsp_type rsp;
      int           hit;
      rsp.status = STAT_OK;
      case (op)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (list_model.size() >= DEPTH) begin
               rsp.status = STAT_FULL;
            end else begin
               if (op == OP_PUSH_FRONT) list_model.push_front(value);
               else list_model.push_back(value);
               if (!value[0]) even_total += value;
            end
         end
         OP_DELETE: begin
            if (list_model.size() == 0) begin
               rsp.status = STAT_EMPTY;
            end else begin
               hit = -1;
               foreach (list_model[k]) begin
                  if (hit < 0 && list_model[k] == value) hit = k;
               end
               if (hit < 0) begin
                  rsp.status = STAT_NOT_FOUND;
               end else begin
                  list_model.delete(hit);
                  if (!value[0]) even_total -= value;
                  if (list_model.size() == 0) even_total = '0;
               end
            end
         end
         default: ;
      endcase
      rsp.count = CNT_W'(list_model.size());
      rsp.sum   = even_total;
      expected_rsp.push_back(rsp);
   endfunction

   // Mostly back-to-back or short gaps, a few long ones, and gap-free bursts
   function automatic int pick_gap();
      int r;
      if (nogap_left > 0) begin
         nogap_left--;
         return 0;
      end
      if ($urandom_range(0, 49) == 0) begin
         nogap_left = $urandom_range(20, 60);
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Driver: a transaction moves when start is high and busy is low
   always @(posedge clock) begin
      if (reset) begin
         start     <= 1'b0;
         req_op    <= OP_PUSH_FRONT;
         req_value <= '0;
         gap_left  = 0;
      end else begin
         if (start && !busy) begin
            predict_list_op(req_op, req_value);
            n_accepted++;
            gap_left = pick_gap();
         end
         // a transaction held off by busy stays on the ports
         if (!(start && busy)) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (pending.size() > 0 &&
                         !(pending[0].drain && expected_rsp.size() > 0)) begin
               head_item = pending.pop_front();
               start     <= 1'b1;
               req_op    <= head_item.op;
               req_value <= head_item.value;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: every strobe is compared with the oldest expected response
   always @(posedge clock) begin
      list_rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_rsp.size() == 0) begin
            report_mismatch($sformatf("response with no transaction pending: status %0d",
                                      rsp_status));
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_status !== want.status)
               report_mismatch($sformatf("rsp %0d status got %0d expected %0d",
                                         n_checked, rsp_status, want.status));
            if (rsp_entry_count !== want.count)
               report_mismatch($sformatf("rsp %0d entry_count got %0d expected %0d",
                                         n_checked, rsp_entry_count, want.count));
            if (rsp_even_sum !== want.sum)
               report_mismatch($sformatf("rsp %0d even_sum got %h expected %h",
                                         n_checked, rsp_even_sum, want.sum));
            n_checked++;
         end
      end
   end

   // Watchdog on cycles where neither side moves a transaction
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d idle cycles, %0d responses outstanding",
                     stall_cycles, expected_rsp.size());
            $display("status: fail");
            $finish;
         end
      end
   end

   // Stimulus and end of run
   initial begin
      int r;
      int ins_pct;
      logic [1:0]        op;
      logic [DATA_W-1:0] value;

      // directed: empty list, unused op, single entry delete, extremes, full list
      queue_item(OP_DELETE, 32'd5, 1'b0);
      queue_item(OP_UNUSED, 32'hFFFF_FFFF, 1'b0);
      queue_item(OP_PUSH_FRONT, 32'd6, 1'b0);
      queue_item(OP_DELETE, 32'd6, 1'b1);
      queue_item(OP_PUSH_BACK, 32'h7FFF_FFFF, 1'b0);
      queue_item(OP_PUSH_FRONT, 32'h8000_0000, 1'b0);
      queue_item(OP_PUSH_BACK, 32'hFFFF_FFFE, 1'b0);
      queue_item(OP_PUSH_FRONT, 32'h0000_0000, 1'b0);
      queue_item(OP_DELETE, 32'd12345, 1'b0);
      queue_item(OP_DELETE, 32'h8000_0000, 1'b0);
      // fill to capacity with duplicates so first-match delete is exercised
      for (int i = 0; i < 13; i++)
         queue_item((i % 2) ? OP_PUSH_BACK : OP_PUSH_FRONT, DATA_W'((i % 4) * 2 - 2), 1'b0);
      queue_item(OP_PUSH_FRONT, 32'd4, 1'b0);
      queue_item(OP_PUSH_BACK, 32'd5, 1'b0);
      queue_item(OP_DELETE, 32'd2, 1'b0);
      queue_item(OP_DELETE, 32'hFFFF_FFFE, 1'b0);
      queue_item(OP_UNUSED, 32'h0, 1'b0);

      // value pool keeps deletes hitting stored entries most of the time
      value_pool[0] = 32'h0;
      value_pool[1] = 32'hFFFF_FFFF;
      value_pool[2] = 32'h8000_0000;
      value_pool[3] = 32'h7FFF_FFFF;
      for (int k = 4; k < POOL_N; k++) begin
         value_pool[k] = $urandom();
         if (k % 2 == 0) value_pool[k][0] = 1'b0;
      end

      // random: segments biased toward filling or toward draining the list
      while (n_items < N_RANDOM + 27) begin
         ins_pct = $urandom_range(0, 1) ? 75 : 30;
         repeat ($urandom_range(20, 60)) begin
            r = $urandom_range(0, 99);
            if (r < 2) op = OP_UNUSED;
            else if (r < ins_pct) op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
            else op = OP_DELETE;
            if ($urandom_range(0, 9) == 0) value = $urandom();
            else value = value_pool[$urandom_range(0, POOL_N - 1)];
            queue_item(op, value, $urandom_range(0, 99) == 0);
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (n_accepted < n_items || expected_rsp.size() > 0) @(posedge clock);
      // let any delete scan finish; catch any stray strobe after the last
      repeat (DEPTH + 4) @(posedge clock);

      if (n_errors == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule

// ===== bounded_list_with_even_sum_core.f =====
+incdir+design
design/blwes_pkg.sv
design/blwes_cell.sv
design/bounded_list_with_even_sum_core.sv
tb/bounded_list_with_even_sum_core_tb.sv
